### rtl/core/mmc_pkg.sv
// Shared constants and types for the min/max accelerometer calibrator.
// No dependencies; imported by every module of the block.
package mmc_pkg;

  // default ADC sample width
  localparam int SAMPLE_BITS_DEF = 12;

  // fixed field widths
  localparam int QUIET_W  = 16;
  localparam int CENTER_W = 12;
  localparam int SCALE_W  = 24;
  localparam int BIAS_W   = 8;

  // register reset values
  localparam logic [QUIET_W-1:0]  IDLE_LIMIT_RST = 16'd60000;
  localparam logic [CENTER_W-1:0] CENTER_RST     = 12'd0;
  localparam logic [SCALE_W-1:0]  SCALE_NUM_RST  = 24'd2563768;

  // saturated scale on a zero range
  localparam logic [SCALE_W-1:0]  SCALE_SAT      = 24'hFFFFFF;

  // register index (word address)
  typedef enum logic [1:0] {
    REG_IDLE_LIMIT = 2'd0,
    REG_CENTER     = 2'd1,
    REG_SCALE_NUM  = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  // outcome of one serial magnitude compare
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

endpackage

### rtl/core/mmc_sercmp.sv
// Bit-serial magnitude comparator, MSB first, one bit per cycle while shift is high.
// Depends on mmc_pkg for the result struct.
module mmc_sercmp
  import mmc_pkg::*;
#(
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  logic         shift,
  input  logic [W-1:0] a_in,
  input  logic [W-1:0] b_in,
  output cmp_res_t     res
);

  logic [W-1:0] a_sh_r;
  logic [W-1:0] b_sh_r;
  logic         lt_r;
  logic         gt_r;

  // operand shift registers
  always_ff @(posedge clk) begin
    if (load) begin
      a_sh_r <= a_in;
      b_sh_r <= b_in;
    end else if (shift) begin
      a_sh_r <= {a_sh_r[W-2:0], 1'b0};
      b_sh_r <= {b_sh_r[W-2:0], 1'b0};
    end
  end

  // first differing bit decides the outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      gt_r <= 1'b0;
    end else if (load) begin
      lt_r <= 1'b0;
      gt_r <= 1'b0;
    end else if (shift && !(lt_r || gt_r)) begin
      lt_r <= ~a_sh_r[W-1] & b_sh_r[W-1];
      gt_r <= a_sh_r[W-1] & ~b_sh_r[W-1];
    end
  end

  assign res.lt = lt_r;
  assign res.gt = gt_r;

endmodule

### rtl/core/mmc_serdiv.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mmc_pkg for the quotient width.
module mmc_serdiv
  import mmc_pkg::*;
#(
  parameter int DW = SAMPLE_BITS_DEF + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SCALE_W-1:0] dividend,
  input  logic [DW-1:0]      divisor,
  output logic               done,
  output logic [SCALE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SCALE_W + 1);

  logic [SCALE_W-1:0] quo_r;
  logic [DW-1:0]      rem_r;
  logic [DW-1:0]      dvs_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [DW+1:0]      diff;
  logic               neg;

  // trial subtract of the shifted partial remainder
  assign diff = {1'b0, rem_r, quo_r[SCALE_W-1]} - {2'b00, dvs_r};
  assign neg  = diff[DW+1];

  // datapath: quotient bits enter as dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SCALE_W-2:0], ~neg};
      if (neg) begin
        rem_r <= {rem_r[DW-2:0], quo_r[SCALE_W-1]};
      end else begin
        rem_r <= diff[DW-1:0];
      end
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SCALE_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/accel_minmax_calibrator.sv
// Top level of the min/max accelerometer calibrator: APB registers, extreme
// tracking, control sequencer and output register.
// Depends on mmc_pkg, mmc_sercmp and mmc_serdiv.
//
// Each input transaction carries one X/Y sample pair. The block compares the
// pair against the stored extremes bit-serially, MSB first, in four serial
// comparators, and takes the next pair only once the compares and the
// extreme update are done. When the quiet count reaches idle_limit a
// result is produced: biases from the midpoints and the scale from a
// one-bit-per-cycle divider. With a zero summed range the divider is skipped,
// the scale saturates and the flag is set. The result waits in an output
// register; a further result waits until that register is taken. Tracking
// state returns to reset after each result.
module accel_minmax_calibrator
  import mmc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [SAMPLE_BITS-1:0] sample_x, [2*SAMPLE_BITS-1:SAMPLE_BITS] sample_y
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] bias_x, [15:8] bias_y, [39:16] scale_q16
  output logic [39:0] out_tdata,
  // [0] zero_range
  output logic        out_tuser,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int RW    = SAMPLE_BITS + 1;
  localparam int CNT_W = $clog2(SAMPLE_BITS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_t;

  // registers
  logic [QUIET_W-1:0]  idle_limit_r;
  logic [CENTER_W-1:0] center_r;
  logic [SCALE_W-1:0]  scale_num_r;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    bit_cnt_r;
  logic [SB-1:0]       sx_r, sy_r;
  logic [SB-1:0]       min_x_r, min_y_r, max_x_r, max_y_r;
  logic [QUIET_W-1:0]  quiet_r;
  logic                fire_r;
  logic [BIAS_W-1:0]   pend_bx_r, pend_by_r;
  logic                pend_zero_r;
  logic                out_valid_r;
  logic [BIAS_W-1:0]   out_bx_r, out_by_r;
  logic [SCALE_W-1:0]  out_scale_r;
  logic                out_zero_r;

  logic                in_acc;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic                cmp_shift;
  cmp_res_t            res_xlo, res_xhi, res_ylo, res_yhi;
  logic                changed;
  logic [QUIET_W-1:0]  quiet_nxt;
  logic [SB-1:0]       min_x_nxt, min_y_nxt, max_x_nxt, max_y_nxt;
  logic [RW:0]         range_wide;
  logic [RW-1:0]       range_sum;
  logic [SB:0]         sum_x, sum_y;
  logic                div_start;
  logic                div_done;
  logic [SCALE_W-1:0]  div_quo;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r <= IDLE_LIMIT_RST;
      center_r     <= CENTER_RST;
      scale_num_r  <= SCALE_NUM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IDLE_LIMIT: idle_limit_r <= cfg_pwdata[QUIET_W-1:0];
        REG_CENTER:     center_r     <= cfg_pwdata[CENTER_W-1:0];
        REG_SCALE_NUM:  scale_num_r  <= cfg_pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_IDLE_LIMIT: cfg_prdata = 32'(idle_limit_r);
      REG_CENTER:     cfg_prdata = 32'(center_r);
      REG_SCALE_NUM:  cfg_prdata = 32'(scale_num_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------ serial compares
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cmp_shift = (state_r == ST_CMP);

  mmc_sercmp #(.W(SB)) u_cmp_xlo (
    .clk(clk), .rst_n(rst_n), .load(in_acc), .shift(cmp_shift),
    .a_in(in_tdata[SB-1:0]), .b_in(min_x_r), .res(res_xlo)
  );
  mmc_sercmp #(.W(SB)) u_cmp_xhi (
    .clk(clk), .rst_n(rst_n), .load(in_acc), .shift(cmp_shift),
    .a_in(in_tdata[SB-1:0]), .b_in(max_x_r), .res(res_xhi)
  );
  mmc_sercmp #(.W(SB)) u_cmp_ylo (
    .clk(clk), .rst_n(rst_n), .load(in_acc), .shift(cmp_shift),
    .a_in(in_tdata[2*SB-1:SB]), .b_in(min_y_r), .res(res_ylo)
  );
  mmc_sercmp #(.W(SB)) u_cmp_yhi (
    .clk(clk), .rst_n(rst_n), .load(in_acc), .shift(cmp_shift),
    .a_in(in_tdata[2*SB-1:SB]), .b_in(max_y_r), .res(res_yhi)
  );

  // ------------------------------------------------------ extreme update
  assign changed   = res_xlo.lt | res_xhi.gt | res_ylo.lt | res_yhi.gt;
  assign quiet_nxt = (changed ? '0 : quiet_r) + 1'b1;
  assign min_x_nxt = res_xlo.lt ? sx_r : min_x_r;
  assign max_x_nxt = res_xhi.gt ? sx_r : max_x_r;
  assign min_y_nxt = res_ylo.lt ? sy_r : min_y_r;
  assign max_y_nxt = res_yhi.gt ? sy_r : max_y_r;

  // ------------------------------------------------------ result figures
  assign range_wide = ({2'b00, max_x_r} + {2'b00, max_y_r})
                    - ({2'b00, min_x_r} + {2'b00, min_y_r});
  assign range_sum  = range_wide[RW-1:0];
  assign sum_x      = {1'b0, max_x_r} + {1'b0, min_x_r};
  assign sum_y      = {1'b0, max_y_r} + {1'b0, min_y_r};
  assign div_start  = (state_r == ST_EVAL) & fire_r & (range_sum != '0);

  mmc_serdiv #(.DW(RW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scale_num_r),
    .divisor  (range_sum),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ------------------------------------------------------ sequencer
  // EVAL is entered twice when a result is due: first to store the
  // extremes, then (fire_r set) to take figures and clear the tracker.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CMP;
      ST_CMP:  if (bit_cnt_r == '0) state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (!fire_r) begin
          state_nxt = (quiet_nxt >= idle_limit_r) ? ST_EVAL : ST_IDLE;
        end else begin
          state_nxt = (range_sum != '0) ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_PUSH;
      ST_PUSH: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      fire_r    <= 1'b0;
      min_x_r   <= '1;
      min_y_r   <= '1;
      max_x_r   <= '0;
      max_y_r   <= '0;
      quiet_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        bit_cnt_r <= CNT_W'(SAMPLE_BITS - 1);
      end else if (cmp_shift) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
      end
      if (state_r == ST_EVAL) begin
        if (!fire_r) begin
          min_x_r <= min_x_nxt;
          max_x_r <= max_x_nxt;
          min_y_r <= min_y_nxt;
          max_y_r <= max_y_nxt;
          quiet_r <= quiet_nxt;
          fire_r  <= (quiet_nxt >= idle_limit_r);
        end else begin
          min_x_r <= '1;
          min_y_r <= '1;
          max_x_r <= '0;
          max_y_r <= '0;
          quiet_r <= '0;
          fire_r  <= 1'b0;
        end
      end
    end
  end

  // sample capture and pending result figures
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sx_r <= in_tdata[SB-1:0];
      sy_r <= in_tdata[2*SB-1:SB];
    end
    if ((state_r == ST_EVAL) && fire_r) begin
      pend_bx_r   <= sum_x[BIAS_W:1] - center_r[BIAS_W-1:0];
      pend_by_r   <= sum_y[BIAS_W:1] - center_r[BIAS_W-1:0];
      pend_zero_r <= (range_sum == '0);
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_PUSH) && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_PUSH) && (!out_valid_r || out_tready)) begin
      out_bx_r    <= pend_bx_r;
      out_by_r    <= pend_by_r;
      out_scale_r <= pend_zero_r ? SCALE_SAT : div_quo;
      out_zero_r  <= pend_zero_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_scale_r, out_by_r, out_bx_r};
  assign out_tuser  = out_zero_r;

`ifndef SYNTHESIS
  // tracker is back at reset once the result figures have been taken
  a_clear_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) && fire_r |=>
      (min_x_r == '1) && (max_y_r == '0) && (quiet_r == '0))
    else $error("tracker not cleared after result");

  // divider never started on a zero range
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (range_sum != '0))
    else $error("divider started with zero divisor");

  // a fresh result only comes from the push step
  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_PUSH))
    else $error("result raised outside push step");

  // zero range flag goes with a saturated scale
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[39:16] == SCALE_SAT))
    else $error("zero range without saturated scale");
`endif

endmodule
